// File: design/mlpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multi-level priority queue.
// Depends on nothing; the channels, level controller and top level refer to it by scoped names.
package mlpq_pkg;

   // Fixed widths of the transaction fields.
   localparam int ELEMENT_FIELD_BITS = 32;
   localparam int PRIORITY_BITS      = 5;
   localparam int LEVEL_FIELD_BITS   = 4;
   localparam int STATUS_BITS        = 2;

   // Request opcodes carried in req_type.
   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_DEQUEUE = 1'b1
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NULL    = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   // Outcome of one request, passed from the level controller to the top level.
   typedef struct packed {
      status_type                  status;
      logic [LEVEL_FIELD_BITS-1:0] level;
      logic                        now_empty;
      logic                        deq_ok;
   } step_result_type;

endpackage

// File: design/mlpq_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the priority queue.
// Depends on mlpq_pkg for the field widths.

interface mlpq_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       req_type;
   logic [mlpq_pkg::ELEMENT_FIELD_BITS-1:0]    element_in;
   logic signed [mlpq_pkg::PRIORITY_BITS-1:0]  priority_in;

   modport source (output valid, req_type, element_in, priority_in, input ready);
   modport sink   (input valid, req_type, element_in, priority_in, output ready);
endinterface

interface mlpq_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic [mlpq_pkg::STATUS_BITS-1:0]           status;
   logic [mlpq_pkg::ELEMENT_FIELD_BITS-1:0]    element_out;
   logic [mlpq_pkg::LEVEL_FIELD_BITS-1:0]      level_out;
   logic                                       now_empty;

   modport source (output valid, status, element_out, level_out, now_empty, input ready);
   modport sink   (input valid, status, element_out, level_out, now_empty, output ready);
endinterface

// File: design/mlpq_slot_ram.sv
`timescale 1ns / 1ps
// Handle storage of the priority queue: one write port, one registered read port.
// Depends on nothing but its parameters.
module mlpq_slot_ram #(
   parameter int DATA_BITS = 32,
   parameter int ADDR_BITS = 6,
   parameter int DEPTH     = 64
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/mlpq_level_ctrl.sv
`timescale 1ns / 1ps
// Per-level ring pointers and occupancy counts, priority encoder and request decision.
// Depends on mlpq_pkg for the status codes and the result struct.
module mlpq_level_ctrl #(
   parameter int LEVELS          = 4,
   parameter int SLOTS_PER_LEVEL = 16,
   parameter int LEVEL_BITS      = 2,
   parameter int PTR_BITS        = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     step,
   input  logic                                     cmd_dequeue,
   input  logic                                     elem_null,
   input  logic signed [mlpq_pkg::PRIORITY_BITS-1:0] priority_in,
   output mlpq_pkg::step_result_type                result,
   output logic                                     wr_en,
   output logic [LEVEL_BITS+PTR_BITS-1:0]           wr_addr,
   output logic                                     rd_en,
   output logic [LEVEL_BITS+PTR_BITS-1:0]           rd_addr
);

   localparam int COUNT_BITS = $clog2(SLOTS_PER_LEVEL + 1);

   logic [PTR_BITS-1:0]   head_ff  [LEVELS];
   logic [PTR_BITS-1:0]   tail_ff  [LEVELS];
   logic [COUNT_BITS-1:0] count_ff [LEVELS];
   logic [COUNT_BITS-1:0] count_in [LEVELS];

   logic [LEVEL_BITS-1:0] enq_level;
   logic [LEVEL_BITS-1:0] top_level;
   logic                  any_held;
   logic                  level_full;
   logic                  enq_ok;
   logic                  deq_ok;
   logic                  all_empty;
   logic [PTR_BITS-1:0]   enq_ptr;
   logic [PTR_BITS-1:0]   deq_ptr;

   // Clamp the signed priority into 0..LEVELS-1.
   always_comb begin
      if (priority_in[mlpq_pkg::PRIORITY_BITS-1]) begin
         enq_level = '0;
      end else if (mlpq_pkg::PRIORITY_BITS'(priority_in[mlpq_pkg::PRIORITY_BITS-2:0]) >
                   mlpq_pkg::PRIORITY_BITS'(LEVELS - 1)) begin
         enq_level = LEVEL_BITS'(LEVELS - 1);
      end else begin
         enq_level = LEVEL_BITS'(priority_in[mlpq_pkg::PRIORITY_BITS-2:0]);
      end
   end

   // Highest nonempty level; the later match wins, so the scan runs upward.
   always_comb begin
      top_level = '0;
      any_held  = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (count_ff[l] != '0) begin
            top_level = LEVEL_BITS'(l);
            any_held  = 1'b1;
         end
      end
   end

   // Decide what the request does.
   assign level_full = (count_ff[enq_level] == COUNT_BITS'(SLOTS_PER_LEVEL));
   assign enq_ok     = !cmd_dequeue && !elem_null && !level_full;
   assign deq_ok     = cmd_dequeue && any_held;
   assign enq_ptr    = tail_ff[enq_level];
   assign deq_ptr    = head_ff[top_level];

   // Occupancy after this request, and the emptiness it leaves behind.
   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         count_in[l] = count_ff[l];
      end
      if (enq_ok) begin
         count_in[enq_level] = count_ff[enq_level] + COUNT_BITS'(1);
      end
      if (deq_ok) begin
         count_in[top_level] = count_ff[top_level] - COUNT_BITS'(1);
      end
      all_empty = 1'b1;
      for (int l = 0; l < LEVELS; l++) begin
         if (count_in[l] != '0) begin
            all_empty = 1'b0;
         end
      end
   end

   // Result of the request.
   always_comb begin
      result.now_empty = all_empty;
      result.deq_ok    = deq_ok;
      if (cmd_dequeue) begin
         result.status = any_held ? mlpq_pkg::STATUS_OK : mlpq_pkg::STATUS_EMPTY;
         result.level  = any_held ? mlpq_pkg::LEVEL_FIELD_BITS'(top_level) : '0;
      end else begin
         if (elem_null) begin
            result.status = mlpq_pkg::STATUS_NULL;
         end else if (level_full) begin
            result.status = mlpq_pkg::STATUS_FULL;
         end else begin
            result.status = mlpq_pkg::STATUS_OK;
         end
         result.level = mlpq_pkg::LEVEL_FIELD_BITS'(enq_level);
      end
   end

   // Storage accesses; the slot address is the level on top of the ring index.
   assign wr_en   = step && enq_ok;
   assign wr_addr = {enq_level, enq_ptr};
   assign rd_en   = step && deq_ok;
   assign rd_addr = {top_level, deq_ptr};

   // Pointer and count registers advance once per transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
      end else if (step) begin
         for (int l = 0; l < LEVELS; l++) begin
            count_ff[l] <= count_in[l];
         end
         if (enq_ok) begin
            tail_ff[enq_level] <= (enq_ptr == PTR_BITS'(SLOTS_PER_LEVEL - 1)) ?
                                  '0 : enq_ptr + PTR_BITS'(1);
         end
         if (deq_ok) begin
            head_ff[top_level] <= (deq_ptr == PTR_BITS'(SLOTS_PER_LEVEL - 1)) ?
                                  '0 : deq_ptr + PTR_BITS'(1);
         end
      end
   end

endmodule

// File: design/multi_level_priority_fifo_unit.sv
`timescale 1ns / 1ps
// Top level of the multi-level priority queue: request register, level controller,
// handle storage and result register. Depends on mlpq_pkg, mlpq_channels,
// mlpq_level_ctrl and mlpq_slot_ram.
//
//   Channel    Dir  Payload                                       Completes when
//   req_chan   in   req_type, element_in, priority_in             valid && ready
//   rsp_chan   out  status, element_out, level_out, now_empty     valid && ready
//
// One request per cycle is taken while the result channel keeps up; each result
// passes first through the request register, then the decision and storage
// access land in the result register and the storage read register together.
// Reset is synchronous and empties every level; stored handles need no clearing.
// A stalled result holds both registers, and a new request is still taken while
// the result register can move on in the same cycle.
module multi_level_priority_fifo_unit #(
   parameter int LEVELS          = 4,
   parameter int SLOTS_PER_LEVEL = 16,
   parameter int ELEMENT_BITS    = 32
) (
   input logic        clock,
   input logic        reset,
   mlpq_req_if.sink   req_chan,
   mlpq_rsp_if.source rsp_chan
);

   localparam int LEVEL_BITS = $clog2(LEVELS);
   localparam int PTR_BITS   = $clog2(SLOTS_PER_LEVEL);
   localparam int ADDR_BITS  = LEVEL_BITS + PTR_BITS;
   localparam int RAM_DEPTH  = LEVELS << PTR_BITS;

   logic                                       in_vld_ff;
   logic                                       in_deq_ff;
   logic [ELEMENT_BITS-1:0]                    in_elem_ff;
   logic signed [mlpq_pkg::PRIORITY_BITS-1:0]  in_prio_ff;
   logic                                       out_vld_ff;
   mlpq_pkg::step_result_type                  out_res_ff;

   logic                                       step;
   mlpq_pkg::step_result_type                  step_res;
   logic                                       wr_en;
   logic [ADDR_BITS-1:0]                       wr_addr;
   logic                                       rd_en;
   logic [ADDR_BITS-1:0]                       rd_addr;
   logic [ELEMENT_BITS-1:0]                    rd_data;

   // Handshake: the request register moves whenever the result register is free.
   assign step           = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || step;

   // Request register; the handle is kept to the stored width on the way in.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         in_deq_ff  <= (req_chan.req_type == mlpq_pkg::REQ_DEQUEUE);
         in_elem_ff <= ELEMENT_BITS'(req_chan.element_in);
         in_prio_ff <= req_chan.priority_in;
      end
   end

   mlpq_level_ctrl #(
      .LEVELS          (LEVELS),
      .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL),
      .LEVEL_BITS      (LEVEL_BITS),
      .PTR_BITS        (PTR_BITS)
   ) u_level_ctrl (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .cmd_dequeue (in_deq_ff),
      .elem_null   (in_elem_ff == '0),
      .priority_in (in_prio_ff),
      .result      (step_res),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   mlpq_slot_ram #(
      .DATA_BITS (ELEMENT_BITS),
      .ADDR_BITS (ADDR_BITS),
      .DEPTH     (RAM_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_elem_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result register, loaded in step with the storage read register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_chan.ready) begin
         out_vld_ff <= in_vld_ff;
      end
      if (step) begin
         out_res_ff <= step_res;
      end
   end

   // Result fields; the handle shows only for a dequeue that found one.
   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.status      = out_res_ff.status;
   assign rsp_chan.level_out   = out_res_ff.level;
   assign rsp_chan.now_empty   = out_res_ff.now_empty;
   assign rsp_chan.element_out = out_res_ff.deq_ok ?
                                 mlpq_pkg::ELEMENT_FIELD_BITS'(rd_data) : '0;

endmodule
